FILE: hdl/aid_pkg.sv
package aid_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned THR_W    = 12;
  localparam int unsigned THR_SQ_W = 2 * THR_W;
  localparam int unsigned AXES     = 3;
  localparam int unsigned SQ_W     = 2 * SAMPLE_W;
  localparam int unsigned DIST_W   = SQ_W + 2;
  localparam int unsigned WARN_W   = DIST_W + 5;

  // threshold register reset
  localparam int unsigned THR_RESET = 80;
  localparam logic [THR_SQ_W-1:0] THR_SQ_RESET = THR_SQ_W'(THR_RESET * THR_RESET);

  // early warning at 64/100 of threshold squared, as a cross-multiplied compare
  localparam int unsigned WARN_NUM   = 64;
  localparam int unsigned WARN_DEN   = 100;
  localparam int unsigned WARN_GCD   = 4;
  localparam int unsigned WARN_MUL_D = WARN_DEN / WARN_GCD;
  localparam int unsigned WARN_MUL_T = WARN_NUM / WARN_GCD;

  // mode codes
  localparam logic [1:0] MODE_DISARMED = 2'd0;
  localparam logic [1:0] MODE_ARMED    = 2'd1;
  localparam logic [1:0] MODE_ALARM    = 2'd2;

  // action codes
  localparam logic ACT_COMMAND = 1'b0;
  localparam logic ACT_SAMPLE  = 1'b1;

  typedef struct packed {
    logic                       action;
    logic                       arm_request;
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
    logic signed [SAMPLE_W-1:0] sample_z;
  } in_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       mode_changed;
    logic       early_warning;
  } out_t;

  typedef struct packed {
    logic [1:0]                     mode;
    logic [AXES-1:0][SAMPLE_W-1:0]  base;
    logic [AXES-1:0][SAMPLE_W-1:0]  last;
  } state_t;

endpackage

FILE: hdl/armed_impact_detector.sv
// armed impact detector: arm commands and three-axis samples in, one result per beat out
// path: an accepted beat is held in the input register, then its result in the result register
// throughput: one beat per cycle while not stalled; the mode and baseline update in the
//   same cycle as the distance check, so each item sees the state the previous item left
// reset: mode disarmed, last sample and baseline zero, threshold 80, both stages empty
module armed_impact_detector (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  aid_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output aid_pkg::out_t              out_data_o,
  input  logic                       cfg_we_i,
  input  logic [aid_pkg::THR_W-1:0]  cfg_data_i
);
  import aid_pkg::*;

  logic                s1_valid_q;
  in_t                 s1_item_q;
  logic                out_valid_q;
  out_t                out_q;
  state_t              state_q;
  state_t              state_d;
  out_t                result_d;
  logic [THR_SQ_W-1:0] thr_sq_q;
  logic [THR_SQ_W-1:0] thr_sq_d;
  logic                advance;
  logic                in_fire;

  // stage one moves into the result register when that is free or being drained
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  // threshold squared kept ready for the compare
  assign thr_sq_d = {{THR_W{1'b0}}, cfg_data_i} * {{THR_W{1'b0}}, cfg_data_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_sq_q <= THR_SQ_RESET;
    end else if (cfg_we_i) begin
      thr_sq_q <= thr_sq_d;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_data_i;
    end
  end

  aid_eval u_eval (
    .item_i   (s1_item_q),
    .state_i  (state_q),
    .thr_sq_i (thr_sq_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // detector state advances with each item leaving stage one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_valid_q && advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && advance) begin
      out_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hdl/aid_eval.sv
module aid_eval (
  input  aid_pkg::in_t                      item_i,
  input  aid_pkg::state_t                   state_i,
  input  logic [aid_pkg::THR_SQ_W-1:0]      thr_sq_i,
  output aid_pkg::state_t                   state_o,
  output aid_pkg::out_t                     result_o
);
  import aid_pkg::*;

  logic [AXES-1:0][SAMPLE_W-1:0] sample;
  logic [AXES-1:0][SAMPLE_W:0]   diff;
  logic [AXES-1:0][SAMPLE_W-1:0] mag;
  logic [AXES-1:0][SQ_W-1:0]     sq;
  logic [DIST_W-1:0]             dist_sum;
  logic [WARN_W-1:0]             warn_lhs;
  logic [WARN_W-1:0]             warn_rhs;
  logic                          alarm_hit;
  logic                          warn_hit;
  logic [1:0]                    mode_prev;
  logic                          warn;

  assign sample[0] = item_i.sample_x;
  assign sample[1] = item_i.sample_y;
  assign sample[2] = item_i.sample_z;

  // per-axis distance from baseline, squared
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      diff[i] = {sample[i][SAMPLE_W-1], sample[i]} -
                {state_i.base[i][SAMPLE_W-1], state_i.base[i]};
      mag[i]  = diff[i][SAMPLE_W] ? SAMPLE_W'(-diff[i]) : diff[i][SAMPLE_W-1:0];
      sq[i]   = SQ_W'(mag[i]) * SQ_W'(mag[i]);
    end
  end

  assign dist_sum = DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]);

  // alarm above t^2, warning above floor(t^2 * 64 / 100)
  assign alarm_hit = dist_sum > DIST_W'(thr_sq_i);
  assign warn_lhs  = WARN_W'(dist_sum) * WARN_W'(WARN_MUL_D);
  assign warn_rhs  = WARN_W'(thr_sq_i) * WARN_W'(WARN_MUL_T);
  assign warn_hit  = warn_lhs > warn_rhs;

  // unused mode code falls back to disarmed
  assign mode_prev = (state_i.mode == MODE_ARMED || state_i.mode == MODE_ALARM) ?
                     state_i.mode : MODE_DISARMED;

  // mode update and sample bookkeeping
  always_comb begin
    state_o      = state_i;
    state_o.mode = mode_prev;
    warn         = 1'b0;
    if (item_i.action == ACT_COMMAND) begin
      if (item_i.arm_request) begin
        if (mode_prev == MODE_DISARMED) begin
          state_o.mode = MODE_ARMED;
          state_o.base = state_i.last;
        end else begin
          state_o.mode = MODE_DISARMED;
        end
      end
    end else begin
      state_o.last = sample;
      if (mode_prev == MODE_ARMED) begin
        warn = warn_hit;
        if (alarm_hit) begin
          state_o.mode = MODE_ALARM;
        end
      end
    end
  end

  assign result_o.mode          = state_o.mode;
  assign result_o.mode_changed  = state_o.mode != mode_prev;
  assign result_o.early_warning = warn;

endmodule

FILE: hdl/aid_checker.sv
module aid_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       out_valid_o,
  input  logic                       out_ready_i,
  input  aid_pkg::out_t              out_data_o
);
  import aid_pkg::*;

  logic [1:0] prev_mode_q;
  logic       out_beat;

  assign out_beat = out_valid_o && out_ready_i;

  // mode of the last delivered beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_mode_q <= MODE_DISARMED;
    end else if (out_beat) begin
      prev_mode_q <= out_data_o.mode;
    end
  end

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  // the change flag matches the delivered mode sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.mode_changed == (out_data_o.mode != prev_mode_q))
    else $error("mode_changed disagrees with mode sequence");

  // alarm only clears through disarm
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && prev_mode_q == MODE_ALARM |-> out_data_o.mode != MODE_ARMED)
    else $error("alarm went straight back to armed");

  // warnings only come from an armed sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.early_warning |->
      prev_mode_q == MODE_ARMED &&
      (out_data_o.mode == MODE_ARMED || out_data_o.mode == MODE_ALARM))
    else $error("early warning outside armed mode");

  // alarm is only entered from armed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.mode == MODE_ALARM && prev_mode_q != MODE_ALARM |->
      prev_mode_q == MODE_ARMED)
    else $error("alarm entered from disarmed");

endmodule

bind armed_impact_detector aid_checker u_aid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
